FILE: rtl/csc_pkg.sv
package csc_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HIGH = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_NINE = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUMID      = 8'd4;

  // Divider width, one quotient bit per stage
  localparam int unsigned DIV_W = 64;

  localparam logic [63:0] FINE_OFS_P  = 64'd128000;
  localparam logic [31:0] FINE_OFS_H  = 32'd76800;
  localparam logic [31:0] HUM_MAX     = 32'd419430400;
  localparam logic [63:0] PRESS_SCALE = 64'd3125;

  // Partial products of a 64 x 64 product, low 64 bits kept
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
  } pp_t;

  // Finished fields that ride along with the division
  typedef struct packed {
    logic [15:0] temp;
    logic [16:0] hum;
    logic        inv;
  } side_t;

  // Partial remainder and shifting numerator / quotient
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] nq;
  } divs_t;

  function automatic pp_t pp_f(logic [63:0] a, logic [63:0] b);
    pp_t p;
    p.ll = 64'(a[31:0]) * 64'(b[31:0]);
    p.lh = a[31:0] * b[63:32];
    p.hl = a[63:32] * b[31:0];
    return p;
  endfunction

  function automatic logic [63:0] pp_sum(pp_t p);
    logic [31:0] mid;
    mid = p.lh + p.hl;
    return p.ll + {mid, 32'b0};
  endfunction

  function automatic logic [31:0] sra32(logic [31:0] x, int unsigned s);
    return $signed(x) >>> s;
  endfunction

  function automatic logic [63:0] sra64(logic [63:0] x, int unsigned s);
    return $signed(x) >>> s;
  endfunction

  function automatic logic [63:0] sx16(logic [15:0] f);
    return {{48{f[15]}}, f};
  endfunction

  // One restoring division step
  function automatic divs_t div_step(divs_t s, logic [DIV_W-1:0] d);
    divs_t o;
    logic [DIV_W-1:0] t;
    logic             bit_q;
    t = {s.rem[DIV_W-2:0], s.nq[DIV_W-1]};
    bit_q = (t >= d);
    o.rem = bit_q ? t - d : t;
    o.nq  = {s.nq[DIV_W-2:0], bit_q};
    return o;
  endfunction

endpackage

FILE: rtl/csc_in_if.sv
interface csc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  logic [15:0] raw_humidity;

  modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

FILE: rtl/csc_out_if.sv
interface csc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] temperature_centi;
  logic [31:0] pressure_q24_8;
  logic [16:0] humidity_q22_10;
  logic        pressure_invalid;

  modport source (output valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                  pressure_invalid, input ready);
  modport sink (input valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                pressure_invalid, output ready);
endinterface

FILE: rtl/csc_cfg_if.sv
interface csc_cfg_if import csc_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [63:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/csc_div.sv
module csc_div import csc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [DIV_W-1:0] in_num,
  input  logic [DIV_W-1:0] in_den,
  input  logic             in_neg,
  input  side_t            in_side,
  output logic             out_vld,
  output logic [DIV_W-1:0] out_quo,
  output logic             out_neg,
  output side_t            out_side
);

  logic             vld_r  [DIV_W];
  divs_t            st_r   [DIV_W];
  logic [DIV_W-1:0] den_r  [DIV_W];
  logic             neg_r  [DIV_W];
  side_t            side_r [DIV_W];

  // One quotient bit per stage, all stages advance together
  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    divs_t            src_st;
    logic [DIV_W-1:0] src_den;
    logic             src_vld;
    logic             src_neg;
    side_t            src_side;

    if (k == 0) begin : g_first
      assign src_st   = '{rem: '0, nq: in_num};
      assign src_den  = in_den;
      assign src_vld  = in_vld;
      assign src_neg  = in_neg;
      assign src_side = in_side;
    end else begin : g_rest
      assign src_st   = st_r[k-1];
      assign src_den  = den_r[k-1];
      assign src_vld  = vld_r[k-1];
      assign src_neg  = neg_r[k-1];
      assign src_side = side_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k]   <= div_step(src_st, src_den);
        den_r[k]  <= src_den;
        neg_r[k]  <= src_neg;
        side_r[k] <= src_side;
      end
    end
  end

  assign out_vld  = vld_r[DIV_W-1];
  assign out_quo  = st_r[DIV_W-1].nq;
  assign out_neg  = neg_r[DIV_W-1];
  assign out_side = side_r[DIV_W-1];

endmodule

FILE: rtl/climate_sensor_compensation.sv
// Integer compensation of raw temperature, pressure and humidity samples. One item is
// accepted every clock cycle unless the output stalls. The pipeline holds 15 stages of
// temperature, humidity and pressure polynomial work, a 64-stage divider producing one
// quotient bit per stage, and 6 stages of pressure correction ending in the output
// register. Any stall at the output freezes the whole pipeline. Coefficients are read
// live from the configuration registers, so write them only while the block is empty.
module climate_sensor_compensation import csc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  csc_in_if.sink     in_chan,
  csc_out_if.source  out_chan,
  csc_cfg_if.sink    cfg_chan
);

  // Configuration registers
  logic [47:0] temp_coeffs_r;
  logic [63:0] press_lo_r, press_hi_r, humid_r;
  logic [15:0] press_nine_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_lo_r    <= '0;
      press_hi_r    <= '0;
      press_nine_r  <= '0;
      humid_r       <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_TEMP:       temp_coeffs_r <= cfg_chan.data[47:0];
        CFG_PRESS_LOW:  press_lo_r    <= cfg_chan.data;
        CFG_PRESS_HIGH: press_hi_r    <= cfg_chan.data;
        CFG_PRESS_NINE: press_nine_r  <= cfg_chan.data[15:0];
        CFG_HUMID:      humid_r       <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // Coefficient fields
  logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = {16'b0, temp_coeffs_r[15:0]};
  assign t2 = {{16{temp_coeffs_r[31]}}, temp_coeffs_r[31:16]};
  assign t3 = {{16{temp_coeffs_r[47]}}, temp_coeffs_r[47:32]};
  assign p1 = {48'b0, press_lo_r[15:0]};
  assign p2 = sx16(press_lo_r[31:16]);
  assign p3 = sx16(press_lo_r[47:32]);
  assign p4 = sx16(press_lo_r[63:48]);
  assign p5 = sx16(press_hi_r[15:0]);
  assign p6 = sx16(press_hi_r[31:16]);
  assign p7 = sx16(press_hi_r[47:32]);
  assign p8 = sx16(press_hi_r[63:48]);
  assign p9 = sx16(press_nine_r);
  assign h1 = {24'b0, humid_r[7:0]};
  assign h2 = {{16{humid_r[23]}}, humid_r[23:8]};
  assign h3 = {24'b0, humid_r[31:24]};
  assign h4 = {{20{humid_r[43]}}, humid_r[43:32]};
  assign h5 = {{20{humid_r[55]}}, humid_r[55:44]};
  assign h6 = {{24{humid_r[63]}}, humid_r[63:56]};

  // Advance the whole pipeline unless a result waits at the output
  logic adv;
  logic out_vld_r;

  assign adv           = !out_vld_r || out_chan.ready;
  assign in_chan.ready = adv;

  // Stage valid bits
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r, s7_vld_r, s8_vld_r;
  logic s9_vld_r, s10_vld_r, s11_vld_r, s12_vld_r, s13_vld_r, s14_vld_r, s15_vld_r;
  logic d1_vld_r, d2_vld_r, d3_vld_r, d4_vld_r, d5_vld_r;
  logic div_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0; s2_vld_r  <= 1'b0; s3_vld_r  <= 1'b0; s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0; s6_vld_r  <= 1'b0; s7_vld_r  <= 1'b0; s8_vld_r  <= 1'b0;
      s9_vld_r  <= 1'b0; s10_vld_r <= 1'b0; s11_vld_r <= 1'b0; s12_vld_r <= 1'b0;
      s13_vld_r <= 1'b0; s14_vld_r <= 1'b0; s15_vld_r <= 1'b0;
      d1_vld_r  <= 1'b0; d2_vld_r  <= 1'b0; d3_vld_r  <= 1'b0; d4_vld_r  <= 1'b0;
      d5_vld_r  <= 1'b0; out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_chan.valid;
      s2_vld_r  <= s1_vld_r;  s3_vld_r  <= s2_vld_r;  s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r;  s6_vld_r  <= s5_vld_r;  s7_vld_r  <= s6_vld_r;
      s8_vld_r  <= s7_vld_r;  s9_vld_r  <= s8_vld_r;  s10_vld_r <= s9_vld_r;
      s11_vld_r <= s10_vld_r; s12_vld_r <= s11_vld_r; s13_vld_r <= s12_vld_r;
      s14_vld_r <= s13_vld_r; s15_vld_r <= s14_vld_r;
      d1_vld_r  <= div_vld;   d2_vld_r  <= d1_vld_r;  d3_vld_r  <= d2_vld_r;
      d4_vld_r  <= d3_vld_r;  d5_vld_r  <= d4_vld_r;  out_vld_r <= d5_vld_r;
    end
  end

  // Stage 1: temperature differences and first products
  logic [31:0] s1_at_r, s1_bb_r;
  logic [19:0] s1_adcp_r;
  logic [15:0] s1_adch_r;
  logic [31:0] ta, tb;

  assign ta = {15'b0, in_chan.raw_temperature[19:3]} - (t1 << 1);
  assign tb = {16'b0, in_chan.raw_temperature[19:4]} - t1;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_at_r   <= ta * t2;
      s1_bb_r   <= tb * tb;
      s1_adcp_r <= in_chan.raw_pressure;
      s1_adch_r <= in_chan.raw_humidity;
    end
  end

  // Stage 2: second temperature term
  logic [31:0] s2_tv1_r, s2_m_r;
  logic [19:0] s2_adcp_r;
  logic [15:0] s2_adch_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_tv1_r  <= sra32(s1_at_r, 11);
      s2_m_r    <= sra32(s1_bb_r, 12) * t3;
      s2_adcp_r <= s1_adcp_r;
      s2_adch_r <= s1_adch_r;
    end
  end

  // Stage 3: fine temperature
  logic [31:0] s3_fine_r;
  logic [19:0] s3_adcp_r;
  logic [15:0] s3_adch_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_fine_r <= s2_tv1_r + sra32(s2_m_r, 14);
      s3_adcp_r <= s2_adcp_r;
      s3_adch_r <= s2_adch_r;
    end
  end

  // Stage 4: saturate temperature, offset fine temperature for both branches
  logic [15:0] s4_temp_r;
  logic [63:0] s4_v1_r;
  logic [31:0] s4_vh_r;
  logic [19:0] s4_adcp_r;
  logic [15:0] s4_adch_r;
  logic [31:0] tc;
  logic [15:0] temp_sat;

  assign tc = sra32(s3_fine_r * 32'd5 + 32'd128, 8);

  always_comb begin
    if ($signed(tc) < -32'sd32768) begin
      temp_sat = 16'h8000;
    end else if ($signed(tc) > 32'sd32767) begin
      temp_sat = 16'h7FFF;
    end else begin
      temp_sat = tc[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_temp_r <= temp_sat;
      s4_v1_r   <= {{32{s3_fine_r[31]}}, s3_fine_r} - FINE_OFS_P;
      s4_vh_r   <= s3_fine_r - FINE_OFS_H;
      s4_adcp_r <= s3_adcp_r;
      s4_adch_r <= s3_adch_r;
    end
  end

  // Stage 5: pressure partial products, humidity first products
  pp_t         s5_ppvv_r, s5_ppv5_r, s5_ppv2_r;
  logic [31:0] s5_hx_r, s5_hya_r, s5_hyb_r;
  logic [15:0] s5_temp_r;
  logic [19:0] s5_adcp_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ppvv_r <= pp_f(s4_v1_r, s4_v1_r);
      s5_ppv5_r <= pp_f(s4_v1_r, p5);
      s5_ppv2_r <= pp_f(s4_v1_r, p2);
      s5_hx_r   <= {2'b0, s4_adch_r, 14'b0} - (h4 << 20) - h5 * s4_vh_r + 32'd16384;
      s5_hya_r  <= s4_vh_r * h6;
      s5_hyb_r  <= s4_vh_r * h3;
      s5_temp_r <= s4_temp_r;
      s5_adcp_r <= s4_adcp_r;
    end
  end

  // Stage 6: sum partial products
  logic [63:0] s6_vv_r, s6_v5_r, s6_v2p_r;
  logic [31:0] s6_hxs_r, s6_hy1_r;
  logic [15:0] s6_temp_r;
  logic [19:0] s6_adcp_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_vv_r   <= pp_sum(s5_ppvv_r);
      s6_v5_r   <= pp_sum(s5_ppv5_r);
      s6_v2p_r  <= pp_sum(s5_ppv2_r);
      s6_hxs_r  <= sra32(s5_hx_r, 15);
      s6_hy1_r  <= sra32(s5_hya_r, 10) * (sra32(s5_hyb_r, 11) + 32'd32768);
      s6_temp_r <= s5_temp_r;
      s6_adcp_r <= s5_adcp_r;
    end
  end

  // Stage 7: square times P6 and P3
  pp_t         s7_ppv6_r, s7_ppv3_r;
  logic [63:0] s7_v5_r, s7_v2p_r;
  logic [31:0] s7_hxs_r, s7_hy3_r;
  logic [15:0] s7_temp_r;
  logic [19:0] s7_adcp_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_ppv6_r <= pp_f(s6_vv_r, p6);
      s7_ppv3_r <= pp_f(s6_vv_r, p3);
      s7_v5_r   <= s6_v5_r;
      s7_v2p_r  <= s6_v2p_r;
      s7_hxs_r  <= s6_hxs_r;
      s7_hy3_r  <= (sra32(s6_hy1_r, 10) + 32'd2097152) * h2;
      s7_temp_r <= s6_temp_r;
      s7_adcp_r <= s6_adcp_r;
    end
  end

  // Stage 8
  logic [63:0] s8_vv6_r, s8_vv3_r, s8_v5_r, s8_v2p_r;
  logic [31:0] s8_hv_r;
  logic [15:0] s8_temp_r;
  logic [19:0] s8_adcp_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_vv6_r  <= pp_sum(s7_ppv6_r);
      s8_vv3_r  <= pp_sum(s7_ppv3_r);
      s8_v5_r   <= s7_v5_r;
      s8_v2p_r  <= s7_v2p_r;
      s8_hv_r   <= s7_hxs_r * sra32(s7_hy3_r + 32'd8192, 14);
      s8_temp_r <= s7_temp_r;
      s8_adcp_r <= s7_adcp_r;
    end
  end

  // Stage 9: combine pressure terms
  logic [63:0] s9_v2a_r, s9_v1a_r;
  logic [31:0] s9_hv_r, s9_qq_r;
  logic [15:0] s9_temp_r;
  logic [19:0] s9_adcp_r;
  logic [31:0] hq;

  assign hq = sra32(s8_hv_r, 15);

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_v2a_r  <= s8_vv6_r + (s8_v5_r << 17) + (p4 << 35);
      s9_v1a_r  <= sra64(s8_vv3_r, 8) + (s8_v2p_r << 12);
      s9_hv_r   <= s8_hv_r;
      s9_qq_r   <= hq * hq;
      s9_temp_r <= s8_temp_r;
      s9_adcp_r <= s8_adcp_r;
    end
  end

  // Stage 10: divisor times P1
  pp_t         s10_ppp1_r;
  logic [63:0] s10_v2a_r;
  logic [31:0] s10_hv_r, s10_qq7_r;
  logic [15:0] s10_temp_r;
  logic [19:0] s10_adcp_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_ppp1_r <= pp_f((64'd1 << 47) + s9_v1a_r, p1);
      s10_v2a_r  <= s9_v2a_r;
      s10_hv_r   <= s9_hv_r;
      s10_qq7_r  <= sra32(s9_qq_r, 7) * h1;
      s10_temp_r <= s9_temp_r;
      s10_adcp_r <= s9_adcp_r;
    end
  end

  // Stage 11: clamp humidity
  logic [63:0] s11_prod1_r, s11_v2a_r;
  logic [16:0] s11_hum_r;
  logic [15:0] s11_temp_r;
  logic [19:0] s11_adcp_r;
  logic [31:0] hfin, hclamp;

  assign hfin = s10_hv_r - sra32(s10_qq7_r, 4);

  always_comb begin
    if (hfin[31]) begin
      hclamp = '0;
    end else if (hfin > HUM_MAX) begin
      hclamp = HUM_MAX;
    end else begin
      hclamp = hfin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_prod1_r <= pp_sum(s10_ppp1_r);
      s11_v2a_r   <= s10_v2a_r;
      s11_hum_r   <= hclamp[28:12];
      s11_temp_r  <= s10_temp_r;
      s11_adcp_r  <= s10_adcp_r;
    end
  end

  // Stage 12: divisor and numerator base
  logic [63:0] s12_v1f_r, s12_nb_r;
  logic [16:0] s12_hum_r;
  logic [15:0] s12_temp_r;
  logic [63:0] pbase;

  assign pbase = 64'(21'h100000 - {1'b0, s11_adcp_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_v1f_r  <= sra64(s11_prod1_r, 33);
      s12_nb_r   <= (pbase << 31) - s11_v2a_r;
      s12_hum_r  <= s11_hum_r;
      s12_temp_r <= s11_temp_r;
    end
  end

  // Stage 13: scale numerator
  pp_t         s13_ppnb_r;
  logic [63:0] s13_v1f_r;
  logic [16:0] s13_hum_r;
  logic [15:0] s13_temp_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s13_ppnb_r <= pp_f(s12_nb_r, PRESS_SCALE);
      s13_v1f_r  <= s12_v1f_r;
      s13_hum_r  <= s12_hum_r;
      s13_temp_r <= s12_temp_r;
    end
  end

  // Stage 14
  logic [63:0] s14_num_r, s14_v1f_r;
  logic [16:0] s14_hum_r;
  logic [15:0] s14_temp_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s14_num_r  <= pp_sum(s13_ppnb_r);
      s14_v1f_r  <= s13_v1f_r;
      s14_hum_r  <= s13_hum_r;
      s14_temp_r <= s13_temp_r;
    end
  end

  // Stage 15: magnitudes and sign for the divider; zero divisor replaced by one
  logic [63:0] s15_an_r, s15_ad_r;
  logic        s15_neg_r;
  side_t       s15_side_r;
  logic        dz;

  assign dz = (s14_v1f_r == '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      s15_an_r        <= s14_num_r[63] ? -s14_num_r : s14_num_r;
      s15_ad_r        <= dz ? 64'd1 : (s14_v1f_r[63] ? -s14_v1f_r : s14_v1f_r);
      s15_neg_r       <= s14_num_r[63] ^ s14_v1f_r[63];
      s15_side_r.temp <= s14_temp_r;
      s15_side_r.hum  <= s14_hum_r;
      s15_side_r.inv  <= dz;
    end
  end

  // Divider
  logic [63:0] div_quo;
  logic        div_neg;
  side_t       div_side;

  csc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (s15_vld_r),
    .in_num   (s15_an_r),
    .in_den   (s15_ad_r),
    .in_neg   (s15_neg_r),
    .in_side  (s15_side_r),
    .out_vld  (div_vld),
    .out_quo  (div_quo),
    .out_neg  (div_neg),
    .out_side (div_side)
  );

  // Post-division stages
  logic [63:0] d1_p_r, d2_p_r, d3_p_r, d4_p_r, d5_p_r;
  side_t       d1_side_r, d2_side_r, d3_side_r, d4_side_r, d5_side_r;
  pp_t         d2_ppps_r, d2_ppp8_r, d4_ppp9_r;
  logic [63:0] d3_pss_r, d3_p8p_r, d4_w2_r, d5_w2_r, d5_p9s_r;
  logic [63:0] pshr;

  assign pshr = sra64(d1_p_r, 13);

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_p_r    <= div_neg ? -div_quo : div_quo;
      d1_side_r <= div_side;
      d2_ppps_r <= pp_f(pshr, pshr);
      d2_ppp8_r <= pp_f(p8, d1_p_r);
      d2_p_r    <= d1_p_r;
      d2_side_r <= d1_side_r;
      d3_pss_r  <= pp_sum(d2_ppps_r);
      d3_p8p_r  <= pp_sum(d2_ppp8_r);
      d3_p_r    <= d2_p_r;
      d3_side_r <= d2_side_r;
      d4_ppp9_r <= pp_f(d3_pss_r, p9);
      d4_w2_r   <= sra64(d3_p8p_r, 19);
      d4_p_r    <= d3_p_r;
      d4_side_r <= d3_side_r;
      d5_p9s_r  <= pp_sum(d4_ppp9_r);
      d5_w2_r   <= d4_w2_r;
      d5_p_r    <= d4_p_r;
      d5_side_r <= d4_side_r;
    end
  end

  // Output register
  logic [15:0] out_temp_r;
  logic [31:0] out_press_r;
  logic [16:0] out_hum_r;
  logic        out_inv_r;
  logic [63:0] pfin;

  assign pfin = sra64(d5_p_r + sra64(d5_p9s_r, 25) + d5_w2_r, 8) + (p7 << 4);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_temp_r  <= d5_side_r.temp;
      out_hum_r   <= d5_side_r.hum;
      out_inv_r   <= d5_side_r.inv;
      out_press_r <= d5_side_r.inv ? 32'd0 : pfin[31:0];
    end
  end

  assign out_chan.valid             = out_vld_r;
  assign out_chan.temperature_centi = out_temp_r;
  assign out_chan.pressure_q24_8    = out_press_r;
  assign out_chan.humidity_q22_10   = out_hum_r;
  assign out_chan.pressure_invalid  = out_inv_r;

  // Checks
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_inv_r |-> out_press_r == 32'd0)
    else $error("pressure not forced to zero on zero divisor");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_hum_r <= 17'd102400)
    else $error("humidity above clamp");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv && s15_vld_r |=> s15_vld_r && $stable(s15_an_r) && $stable(s15_ad_r))
    else $error("pipeline moved during stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r)
    else $error("result valid after reset");

endmodule
